### rtl/bdasc_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// Used by bdasc_cell, bdasc_ser and binary_to_decimal_ascii; no dependencies.

package bdasc_pkg;

    localparam int VALUE_W = 16;
    localparam int CHAR_W  = 6;
    localparam int DIGIT_W = 4;
    localparam int CNT_W   = 4;
    localparam int WIDE_W  = 36;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

    typedef struct packed {
        logic             valid;
        logic             started;
        logic [CNT_W-1:0] count;
    } bdasc_ctl_t;

    function automatic logic [WIDE_W-1:0] pow10(input int n);
        logic [WIDE_W-1:0] p;
        p = WIDE_W'(1);
        for (int k = 0; k < 10; k++)
        begin
            if (k < n)
            begin
                p = (p << 3) + (p << 1);
            end
        end
        return p;
    endfunction

endpackage

### rtl/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter: input saturation, cell chain, serialiser.
// Depends on bdasc_pkg, bdasc_cell and bdasc_ser.
//
// Each request carries an unsigned 16-bit value; the block returns its decimal digits as
// ASCII characters, most significant first, leading zeros suppressed, with last set on the
// units digit (zero gives a single '0'). A value that needs more than MAX_DIGITS positions
// is printed as MAX_DIGITS nines. The value passes a chain of MAX_DIGITS cells, one decimal
// position each, and then the serialiser, whose outputs are registered. The serialiser
// sends one character per cycle while out_stall is low; the cells take further requests
// meanwhile and raise in_stall only when the last cell holds a number that the busy
// serialiser cannot yet load.

module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bdasc_pkg::VALUE_W-1:0]        value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bdasc_pkg::CHAR_W-1:0]         ascii_char,
    output logic                                 last
);

    localparam logic [bdasc_pkg::WIDE_W-1:0] LIMIT = bdasc_pkg::pow10(MAX_DIGITS);

    bdasc_pkg::bdasc_ctl_t                         ctl_w    [MAX_DIGITS+1];
    logic [bdasc_pkg::VALUE_W-1:0]                 rem_w    [MAX_DIGITS+1];
    logic [MAX_DIGITS-1:0][bdasc_pkg::DIGIT_W-1:0] digits_w [MAX_DIGITS+1];
    logic                                          load_ok;
    logic                                          advance;
    logic [bdasc_pkg::WIDE_W-1:0]                  limit_m1;

    assign limit_m1 = LIMIT - bdasc_pkg::WIDE_W'(1);
    assign advance  = !ctl_w[MAX_DIGITS].valid || load_ok;
    assign in_stall = !advance;

    assign ctl_w[0].valid   = in_valid;
    assign ctl_w[0].started = 1'b0;
    assign ctl_w[0].count   = '0;
    assign digits_w[0]      = '0;
    assign rem_w[0]         = (bdasc_pkg::WIDE_W'(value) >= LIMIT)
                              ? limit_m1[bdasc_pkg::VALUE_W-1:0] : value;

    for (genvar g = 0; g < MAX_DIGITS; g++)
    begin : g_cell
        bdasc_cell #(
            .MAX_DIGITS (MAX_DIGITS),
            .POS        (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .ctl_in     (ctl_w[g]),
            .rem_in     (rem_w[g]),
            .digits_in  (digits_w[g]),
            .ctl_out    (ctl_w[g+1]),
            .rem_out    (rem_w[g+1]),
            .digits_out (digits_w[g+1])
        );
    end

    bdasc_ser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (ctl_w[MAX_DIGITS]),
        .digits_in  (digits_w[MAX_DIGITS]),
        .load_ok    (load_ok),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ascii_char (ascii_char),
        .last       (last)
    );

endmodule

### rtl/bdasc_cell.sv
// One decimal position of the converter chain: extracts a digit and passes the remainder on.
// Depends on bdasc_pkg.

module bdasc_cell #(
    parameter int MAX_DIGITS = 5,
    parameter int POS        = 0
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          advance,
    input  bdasc_pkg::bdasc_ctl_t                         ctl_in,
    input  logic [bdasc_pkg::VALUE_W-1:0]                 rem_in,
    input  logic [MAX_DIGITS-1:0][bdasc_pkg::DIGIT_W-1:0] digits_in,
    output bdasc_pkg::bdasc_ctl_t                         ctl_out,
    output logic [bdasc_pkg::VALUE_W-1:0]                 rem_out,
    output logic [MAX_DIGITS-1:0][bdasc_pkg::DIGIT_W-1:0] digits_out
);

    localparam logic [bdasc_pkg::WIDE_W-1:0] WEIGHT = bdasc_pkg::pow10(MAX_DIGITS - 1 - POS);

    logic [8:0]                                    hit;
    logic [bdasc_pkg::DIGIT_W-1:0]                 digit;
    logic [bdasc_pkg::WIDE_W-1:0]                  sub;
    logic                                          emit;
    logic                                          valid_reg;
    logic                                          started_reg;
    logic [bdasc_pkg::CNT_W-1:0]                   count_reg;
    logic [bdasc_pkg::VALUE_W-1:0]                 rem_reg;
    logic [MAX_DIGITS-1:0][bdasc_pkg::DIGIT_W-1:0] digits_reg;
    logic [bdasc_pkg::VALUE_W-1:0]                 rem_next;
    logic [MAX_DIGITS-1:0][bdasc_pkg::DIGIT_W-1:0] digits_next;

    always_comb
    begin
        for (int j = 1; j <= 9; j++)
        begin
            hit[j-1] = bdasc_pkg::WIDE_W'(rem_in) >= WEIGHT * bdasc_pkg::WIDE_W'(j);
        end
        digit = bdasc_pkg::DIGIT_W'($countones(hit));
        sub   = '0;
        for (int j = 1; j <= 9; j++)
        begin
            if (digit == bdasc_pkg::DIGIT_W'(j))
            begin
                sub = WEIGHT * bdasc_pkg::WIDE_W'(j);
            end
        end
        rem_next         = rem_in - sub[bdasc_pkg::VALUE_W-1:0];
        emit             = ctl_in.started || (digit != '0) || (POS == MAX_DIGITS - 1);
        digits_next      = digits_in;
        digits_next[POS] = digit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            started_reg <= emit;
            count_reg   <= ctl_in.count + bdasc_pkg::CNT_W'(emit);
            rem_reg     <= rem_next;
            digits_reg  <= digits_next;
        end
    end

    assign ctl_out.valid   = valid_reg;
    assign ctl_out.started = started_reg;
    assign ctl_out.count   = count_reg;
    assign rem_out         = rem_reg;
    assign digits_out      = digits_reg;

endmodule

### rtl/bdasc_ser.sv
// Character serialiser: loads the digits of one number and sends them one per cycle while out_stall is low.
// Depends on bdasc_pkg.

module bdasc_ser #(
    parameter int MAX_DIGITS = 5
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  bdasc_pkg::bdasc_ctl_t                         ctl_in,
    input  logic [MAX_DIGITS-1:0][bdasc_pkg::DIGIT_W-1:0] digits_in,
    output logic                                          load_ok,
    output logic                                          out_valid,
    input  logic                                          out_stall,
    output logic [bdasc_pkg::CHAR_W-1:0]                  ascii_char,
    output logic                                          last
);

    localparam int IDX_W = $clog2(MAX_DIGITS);

    logic                                          out_free;
    logic                                          emit;
    logic                                          load;
    logic                                          out_valid_reg;
    logic                                          out_valid_next;
    logic [bdasc_pkg::CHAR_W-1:0]                  char_reg;
    logic [bdasc_pkg::CHAR_W-1:0]                  char_next;
    logic                                          last_reg;
    logic                                          last_next;
    logic [IDX_W-1:0]                              idx_reg;
    logic [IDX_W-1:0]                              idx_next;
    logic [bdasc_pkg::CNT_W-1:0]                   left_reg;
    logic [bdasc_pkg::CNT_W-1:0]                   left_next;
    logic [MAX_DIGITS-1:0][bdasc_pkg::DIGIT_W-1:0] digits_reg;
    logic [MAX_DIGITS-1:0][bdasc_pkg::DIGIT_W-1:0] digits_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = out_free && (left_reg != '0);
    assign load_ok  = (left_reg == '0) || ((left_reg == bdasc_pkg::CNT_W'(1)) && out_free);
    assign load     = ctl_in.valid && load_ok;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        left_next      = left_reg;
        digits_next    = digits_reg;
        if (out_free)
        begin
            out_valid_next = (left_reg != '0);
        end
        if (emit)
        begin
            char_next = bdasc_pkg::ASCII_ZERO + bdasc_pkg::CHAR_W'(digits_reg[idx_reg]);
            last_next = (left_reg == bdasc_pkg::CNT_W'(1));
            idx_next  = idx_reg + IDX_W'(1);
            left_next = left_reg - bdasc_pkg::CNT_W'(1);
        end
        if (load)
        begin
            digits_next = digits_in;
            idx_next    = IDX_W'(MAX_DIGITS) - IDX_W'(ctl_in.count);
            left_next   = ctl_in.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        digits_reg <= digits_next;
    end

    assign out_valid  = out_valid_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

    left_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= bdasc_pkg::CNT_W'(MAX_DIGITS))
        else $error("serialiser count beyond digit capacity");

    no_gap_in_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |=> out_valid_reg)
        else $error("gap between characters of one number");

    load_count_sane: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (ctl_in.count != '0) && (ctl_in.count <= bdasc_pkg::CNT_W'(MAX_DIGITS)))
        else $error("request loaded with bad character count");

endmodule
